/* design/humidity_temp_frame_decoder_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the humidity/temperature frame decoder
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_TOP_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define HTFD_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define HTFD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* design/htfd_pkg.sv */
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, codes and CRC helper for the frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htfd_pkg;

	// Result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_TEMP_ERR = 2'd1;
	localparam logic [1:0] STAT_HUM_ERR  = 2'd2;

	// CRC-8, MSB first, no reflection, no final xor
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Byte positions within the six-byte reply
	localparam logic [2:0] POS_T_HI  = 3'd0;
	localparam logic [2:0] POS_T_LO  = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_HI  = 3'd3;
	localparam logic [2:0] POS_H_LO  = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	// Scaling: result = floor(SCALE * raw / 65535) - OFFSET
	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [15:0] TEMP_OFFSET = 16'd4500;
	localparam logic [14:0] HUM_SCALE   = 15'd12500;
	localparam logic [15:0] HUM_OFFSET  = 16'd600;
	localparam logic [13:0] HUM_MAX     = 14'd10000;

	// One decoded frame as handed from the front to the back
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] temp_word;
		logic [15:0] humid_word;
	} frame_rec_t;

	// Queue occupancy flags
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// One byte through the CRC, bit by bit
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* design/humidity_temp_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_top
// Decodes six-byte temperature/humidity replies into checked centi readings.
// ----------------------------------------------------------------------------
// Input stream: one reply byte per transaction in s_axis_tdata; s_axis_tuser
// set marks byte 0 of a reply and restarts the byte count. Bytes are taken
// at one per cycle; s_axis_tready drops only when the frame queue is full.
// The reply is temperature word (high, low), its CRC-8, humidity word
// (high, low), its CRC-8 (poly 0x31, init 0xFF, per word).
// Output stream: one transaction per complete reply, carrying the status in
// m_axis_tuser and both readings in m_axis_tdata.
// Path: the sixth byte pushes a record into the queue; the result then passes
// the multiply stage and the output register.
// Throughput: one byte per cycle, one result per cycle, unless stalled.
// Stall: while m_axis_tready is low the back end holds its result, the
// queue of FIFO_DEPTH frames fills, then input is held off.
// Reset: arst_n clears the byte count, CRC, queue and all valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_top #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [14:0] temp_centi, [28:15] humidity_centi
	output logic [1:0]  m_axis_tuser    // [1:0] status
);
	import htfd_pkg::*;

	`include "humidity_temp_frame_decoder_top_macros.svh"

	fifo_stat_t         fifo_stat;
	frame_rec_t         push_rec;
	frame_rec_t         pop_rec;
	logic               push;
	logic               pop;
	logic signed [14:0] temp_centi;
	logic [13:0]        humidity_centi;

	htfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.data_byte   (s_axis_tdata),
		.frame_start (s_axis_tuser),
		.fifo_stat   (fifo_stat),
		.push        (push),
		.rec         (push_rec)
	);

	htfd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_rec),
		.pop     (pop),
		.rd_data (pop_rec),
		.stat    (fifo_stat)
	);

	htfd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.fifo_stat      (fifo_stat),
		.rec            (pop_rec),
		.pop            (pop),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.status         (m_axis_tuser),
		.temp_centi     (temp_centi),
		.humidity_centi (humidity_centi)
	);

	assign m_axis_tdata = {3'b000, humidity_centi, temp_centi};

	// Checks
	`HTFD_ASSERT_NOW(a_no_overflow, push, !fifo_stat.full, "frame queue overflow")
	`HTFD_ASSERT_NOW(a_no_underflow, pop, !fifo_stat.empty, "frame queue underflow")
	`HTFD_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser <= STAT_HUM_ERR, "bad status code")
	`HTFD_ASSERT_NOW(a_hum_range, m_axis_tvalid, m_axis_tdata[28:15] <= HUM_MAX, "humidity above clamp")
	`HTFD_ASSERT_NEXT(a_push_lands, push && !pop, !fifo_stat.empty, "pushed frame lost")

endmodule

/* design/htfd_front.sv */
// ----------------------------------------------------------------------------
// htfd_front
// Byte framing, per-word CRC check and word capture; emits one frame record
// per complete six-byte reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htfd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	input  htfd_pkg::fifo_stat_t fifo_stat,
	output logic               push,
	output htfd_pkg::frame_rec_t rec
);
	import htfd_pkg::*;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_word_q;
	logic [15:0] humid_word_q;
	logic        temp_good_q;

	logic        accept;
	logic [2:0]  pos;
	logic [7:0]  crc_base;
	logic [7:0]  crc_next;

	assign in_ready = !fifo_stat.full;
	assign accept   = in_valid && in_ready;

	// Effective position: frame start or an out-of-range count restarts
	always_comb begin
		pos      = (frame_start || (pos_q > POS_H_CRC)) ? POS_T_HI : pos_q;
		crc_base = (pos == POS_T_HI) ? CRC_INIT : crc_q;
		crc_next = crc8_update(crc_base, data_byte);
	end

	// Record for the back end, valid on the humidity CRC byte
	always_comb begin
		rec.temp_word  = temp_word_q;
		rec.humid_word = humid_word_q;
		if (!temp_good_q) begin
			rec.status = STAT_TEMP_ERR;
		end else if (crc_base != data_byte) begin
			rec.status = STAT_HUM_ERR;
		end else begin
			rec.status = STAT_OK;
		end
	end

	assign push = accept && (pos == POS_H_CRC);

	// Position and CRC control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_T_HI;
			crc_q <= CRC_INIT;
		end else if (accept) begin
			if (pos == POS_H_CRC) begin
				pos_q <= POS_T_HI;
			end else begin
				pos_q <= pos + 3'd1;
			end
			if (pos == POS_T_CRC || pos == POS_H_CRC) begin
				crc_q <= CRC_INIT;
			end else begin
				crc_q <= crc_next;
			end
		end
	end

	// Word capture and temperature check result
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (pos)
				POS_T_HI:  temp_word_q[15:8]  <= data_byte;
				POS_T_LO:  temp_word_q[7:0]   <= data_byte;
				POS_T_CRC: temp_good_q        <= (crc_base == data_byte);
				POS_H_HI:  humid_word_q[15:8] <= data_byte;
				POS_H_LO:  humid_word_q[7:0]  <= data_byte;
				default: ;
			endcase
		end
	end

endmodule

/* design/htfd_fifo.sv */
// ----------------------------------------------------------------------------
// htfd_fifo
// Small register queue of frame records between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htfd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  htfd_pkg::frame_rec_t wr_data,
	input  logic                 pop,
	output htfd_pkg::frame_rec_t rd_data,
	output htfd_pkg::fifo_stat_t stat
);
	import htfd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	frame_rec_t    mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* design/htfd_back.sv */
// ----------------------------------------------------------------------------
// htfd_back
// Scales raw words to centi-units: multiply stage, then divide by 65535,
// offset, and humidity clamp, into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htfd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  htfd_pkg::fifo_stat_t fifo_stat,
	input  htfd_pkg::frame_rec_t rec,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic signed [14:0]   temp_centi,
	output logic [13:0]          humidity_centi
);
	import htfd_pkg::*;

	logic        valid_s1;
	logic [1:0]  status_s1;
	logic [30:0] temp_prod_s1;
	logic [30:0] hum_prod_s1;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [14:0] temp_q;
	logic [13:0] hum_q;

	logic        adv_out;
	logic        adv_s1;
	logic [31:0] temp_sum;
	logic [31:0] hum_sum;
	logic [15:0] temp_quo;
	logic [15:0] hum_quo;
	logic [15:0] temp_diff;
	logic [15:0] hum_diff;
	logic [13:0] hum_clamp;

	// Output register moves when free or being taken; stage 1 also when empty
	assign adv_out = !out_valid_q || out_ready;
	assign adv_s1  = !valid_s1 || adv_out;
	assign pop     = !fifo_stat.empty && adv_s1;

	// Stage 1: scale products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_s1    <= rec.status;
			temp_prod_s1 <= 31'(TEMP_SCALE) * 31'(rec.temp_word);
			hum_prod_s1  <= 31'(HUM_SCALE) * 31'(rec.humid_word);
		end
	end

	// Divide by 2^16-1 as (x + (x >> 16) + 1) >> 16, exact for x < 2^32
	always_comb begin
		temp_sum  = 32'(temp_prod_s1) + 32'(temp_prod_s1[30:16]) + 32'd1;
		hum_sum   = 32'(hum_prod_s1) + 32'(hum_prod_s1[30:16]) + 32'd1;
		temp_quo  = temp_sum[31:16];
		hum_quo   = hum_sum[31:16];
		temp_diff = temp_quo - TEMP_OFFSET;
		hum_diff  = hum_quo - HUM_OFFSET;
		if (hum_quo < HUM_OFFSET) begin
			hum_clamp = '0;
		end else if (hum_diff > 16'(HUM_MAX)) begin
			hum_clamp = HUM_MAX;
		end else begin
			hum_clamp = hum_diff[13:0];
		end
	end

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s1) begin
			status_q <= status_s1;
			temp_q   <= temp_diff[14:0];
			hum_q    <= hum_clamp;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign temp_centi     = $signed(temp_q);
	assign humidity_centi = hum_q;

endmodule
